// File: design/rfdt_pkg.sv
// ----------------------------------------------------------------------------
// rfdt_pkg
// Shared types, constants and helpers of the recent frame dedup table.
// ----------------------------------------------------------------------------
package rfdt_pkg;

    localparam int DEF_TABLE_ENTRIES = 8;

    localparam logic       CMD_CHECK    = 1'b0;
    localparam logic       CMD_REMEMBER = 1'b1;
    localparam logic [3:0] MAX_LEN      = 4'd8;
    localparam logic [31:0] STAMP_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] uuid;
        logic [3:0]  len;
        logic [63:0] payload;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now_ms;
        logic [31:0] max_age_ms;
        logic [31:0] id;
        logic [31:0] uuid;
        logic [3:0]  len;
        logic [63:0] data;
    } t_req;

    typedef struct packed {
        logic match;
        logic age_ok;
    } t_match;

    typedef struct packed {
        logic   en;
        t_entry entry;
    } t_tbl_wr;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    function automatic logic [3:0] sat_len(input logic [3:0] size);
        sat_len = (size > MAX_LEN) ? MAX_LEN : size;
    endfunction

    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            m[b*8 +: 8] = (len > 4'(b)) ? 8'hFF : 8'h00;
        end
        byte_mask = m;
    endfunction

endpackage

// File: design/rfdt_req_if.sv
// ----------------------------------------------------------------------------
// rfdt_req_if
// Command channel: one beat carries one check or remember command.
// ----------------------------------------------------------------------------
interface rfdt_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] now_ms;
    logic [31:0] max_age_ms;
    logic [31:0] frame_id;
    logic [31:0] frame_uuid;
    logic [3:0]  frame_size;
    logic [63:0] frame_data;

    modport source (
        output valid, command, now_ms, max_age_ms, frame_id, frame_uuid,
               frame_size, frame_data,
        input  ready
    );
    modport sink (
        input  valid, command, now_ms, max_age_ms, frame_id, frame_uuid,
               frame_size, frame_data,
        output ready
    );
endinterface

// File: design/rfdt_rsp_if.sv
// ----------------------------------------------------------------------------
// rfdt_rsp_if
// Result channel: one beat per command.
// ----------------------------------------------------------------------------
interface rfdt_rsp_if;
    logic       valid;
    logic       ready;
    logic       seen_recent;
    logic       was_refreshed;
    logic [5:0] slot_used;

    modport source (
        output valid, seen_recent, was_refreshed, slot_used,
        input  ready
    );
    modport sink (
        input  valid, seen_recent, was_refreshed, slot_used,
        output ready
    );
endinterface

// File: design/rfdt_table.sv
// ----------------------------------------------------------------------------
// rfdt_table
// Entry memory with registered read and per-entry valid flops.
// ----------------------------------------------------------------------------
module rfdt_table
    import rfdt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int IW            = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    input  t_tbl_wr       i_wr,
    input  logic [IW-1:0] i_wr_addr,
    output t_entry        o_rd_entry,
    output logic          o_rd_valid
);

    t_entry                   mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    t_entry                   r_rd_entry;
    logic                     r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr_addr] <= i_wr.entry;
        end
        if (i_rd_en) begin
            r_rd_entry <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_rd_valid = r_rd_valid;

endmodule

// File: design/rfdt_match.sv
// ----------------------------------------------------------------------------
// rfdt_match
// Compare one read-back entry against the held command: key match and age.
// ----------------------------------------------------------------------------
module rfdt_match
    import rfdt_pkg::*;
(
    input  t_entry i_entry,
    input  logic   i_valid,
    input  t_req   i_req,
    output t_match o_res
);

    logic [31:0] age;

    assign age = i_req.now_ms - i_entry.stamp;

    always_comb begin
        o_res.match  = i_valid
                    && (i_entry.id == i_req.id)
                    && (i_entry.uuid == i_req.uuid)
                    && (i_entry.len == i_req.len)
                    && (i_entry.payload == i_req.data);
        o_res.age_ok = (age <= i_req.max_age_ms);
    end

endmodule

// File: design/recent_frame_dedup_table_unit.sv
// ----------------------------------------------------------------------------
// recent_frame_dedup_table_unit
// Recent CAN frame table: check for recent duplicates, remember frames.
//
//   channel  dir  beat                                   handshake
//   i_req    in   command, time, window, frame           valid/ready
//   o_rsp    out  seen_recent, was_refreshed, slot_used  valid/ready
//
// For each command the sequencer walks the entry memory through its single
// read port, one entry a cycle, then a drain state for the last compare and
// a write-back state.
// Reset clears the valid flops at once; no clearing pass.
// The result sits in an output register; a stalled result holds the write
// back step until the register frees, while i_req.ready stays low meanwhile.
// ----------------------------------------------------------------------------
module recent_frame_dedup_table_unit
    import rfdt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rfdt_req_if.sink   i_req,
    rfdt_rsp_if.source o_rsp
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_cmp_idx;
    logic          r_cmp_vld;
    t_req          r_req;

    logic          r_hit, r_free;
    logic [IW-1:0] r_hit_idx, r_free_idx, r_least_idx;
    logic [31:0]   r_least;

    logic          r_o_valid, r_o_seen, r_o_ref;
    logic [5:0]    r_o_slot;

    logic          in_ready, rd_en, out_load, out_free, accept;
    logic          hit_now;
    logic [IW-1:0] rem_slot;
    t_tbl_wr       tbl_wr;
    t_entry        rd_entry;
    logic          rd_valid;
    t_match        mres;

    rfdt_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .IW           (IW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx),
        .i_wr      (tbl_wr),
        .i_wr_addr (rem_slot),
        .o_rd_entry(rd_entry),
        .o_rd_valid(rd_valid)
    );

    rfdt_match u_match (
        .i_entry(rd_entry),
        .i_valid(rd_valid),
        .i_req  (r_req),
        .o_res  (mres)
    );

    assign out_free = !r_o_valid || o_rsp.ready;
    assign accept   = i_req.valid && in_ready;
    assign hit_now  = (r_req.cmd == CMD_CHECK) ? (mres.match && mres.age_ok) : mres.match;
    assign rem_slot = r_hit ? r_hit_idx : (r_free ? r_free_idx : r_least_idx);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE:   in_ready = 1'b1;
            S_SCAN:   rd_en    = 1'b1;
            S_DRAIN:  ;
            S_FINISH: out_load = out_free;
            default:  ;
        endcase
    end

    always_comb begin
        tbl_wr.en             = out_load && (r_req.cmd == CMD_REMEMBER);
        tbl_wr.entry.id       = r_req.id;
        tbl_wr.entry.uuid     = r_req.uuid;
        tbl_wr.entry.len      = r_req.len;
        tbl_wr.entry.payload  = r_req.data;
        tbl_wr.entry.stamp    = r_req.now_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= rd_en;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmp_idx <= r_idx;
        if (accept) begin
            r_req.cmd        <= i_req.command;
            r_req.now_ms     <= i_req.now_ms;
            r_req.max_age_ms <= i_req.max_age_ms;
            r_req.id         <= i_req.frame_id;
            r_req.uuid       <= i_req.frame_uuid;
            r_req.len        <= sat_len(i_req.frame_size);
            r_req.data       <= i_req.frame_data & byte_mask(sat_len(i_req.frame_size));
            r_hit            <= 1'b0;
            r_free           <= 1'b0;
            r_least          <= STAMP_MAX;
            r_least_idx      <= '0;
        end else if (r_cmp_vld) begin
            if (hit_now && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
            end
            if (!rd_valid && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
            if (rd_valid && (rd_entry.stamp < r_least)) begin
                r_least     <= rd_entry.stamp;
                r_least_idx <= r_cmp_idx;
            end
        end
        if (out_load) begin
            r_o_seen <= (r_req.cmd == CMD_CHECK) && r_hit;
            r_o_ref  <= (r_req.cmd == CMD_REMEMBER) && r_hit;
            r_o_slot <= (r_req.cmd == CMD_REMEMBER) ? 6'(rem_slot) : 6'd0;
        end
    end

    assign i_req.ready         = in_ready;
    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.seen_recent   = r_o_seen;
    assign o_rsp.was_refreshed = r_o_ref;
    assign o_rsp.slot_used     = r_o_slot;

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN))
        else $error("accepted beat did not start a scan");

    a_load_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_FINISH))
        else $error("result raised outside write-back");

    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && tbl_wr.en))
        else $error("table read and write in one cycle");

    a_exclusive_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_o_seen && r_o_ref))
        else $error("check and refresh flags both set");

endmodule
